>>> hw/rtl/otsu_pkg.sv
package otsu_pkg;

   localparam int MAX_PIXELS = 65536;
   localparam int LEVELS     = 256;

   localparam int PIX_W = 8;
   localparam int CNT_W = $clog2(MAX_PIXELS + 1);  // bin count / pixel count
   localparam int SUM_W = CNT_W + PIX_W;            // sum of gray levels
   localparam int A_W   = SUM_W + CNT_W;            // s1*N, S*n1 and their difference
   localparam int SQ_W  = 2 * A_W;                  // squared difference
   localparam int PP_W  = 2 * CNT_W;                // n1*n2
   localparam int MC_W  = SQ_W;                     // multiplicand width
   localparam int MP_W  = (A_W > PP_W) ? A_W : PP_W; // multiplier width
   localparam int PW    = MC_W + MP_W;              // full product width

   // multiply steps for one split
   typedef enum logic [2:0] {
      OP_A  = 3'd0,   // s1 * N
      OP_B  = 3'd1,   // S * n1
      OP_SQ = 3'd2,   // d * d
      OP_P  = 3'd3,   // n1 * n2
      OP_L  = 3'd4,   // sq * best_product
      OP_R  = 3'd5    // best_square * p
   } op_type;

   typedef struct packed {
      logic   bin_take;    // pixel word accepted
      logic   init;        // start of search
      logic   rd_search;   // histogram read at split index
      logic   accum;       // add bin into class 1
      logic   mul_start;
      logic   mul_latch;   // product ready, store by op
      op_type op;
      logic   step;        // next split
      logic   load_rsp;
      logic   clear;       // end of image
   } dp_cmd_type;

   typedef struct packed {
      logic no_split;
      logic last_split;
      logic mul_done;
      logic mul_busy;
   } dp_stat_type;

endpackage

>>> hw/rtl/otsu_mul.sv
module otsu_mul (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      mul_start,
   input  logic [otsu_pkg::MC_W-1:0] mul_mcand,
   input  logic [otsu_pkg::MP_W-1:0] mul_mplier,
   output logic                      mul_busy,
   output logic                      mul_done,
   output logic [otsu_pkg::PW-1:0]   mul_prod
);
   import otsu_pkg::*;

   logic [PW-1:0]   mc_ff, mc_in, acc_ff, acc_in;
   logic [MP_W-1:0] mp_ff, mp_in;
   logic            busy_ff, busy_in, done_ff, done_in;

   // shift-add, one multiplier bit per cycle, stops when no ones remain
   always_comb begin
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      acc_in  = acc_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mul_start) begin
         mc_in   = PW'(mul_mcand);
         mp_in   = mul_mplier;
         acc_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mp_ff[0]) begin
            acc_in = acc_ff + mc_ff;
         end
         mc_in = mc_ff << 1;
         mp_in = mp_ff >> 1;
         if ((mp_ff >> 1) == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
      acc_ff <= acc_in;
   end

   assign mul_busy = busy_ff;
   assign mul_done = done_ff;
   assign mul_prod = acc_ff;

endmodule

>>> hw/rtl/otsu_dp.sv
module otsu_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  otsu_pkg::dp_cmd_type       cmd,
   output otsu_pkg::dp_stat_type      stat,
   input  logic [otsu_pkg::PIX_W-1:0] req_pixel,
   output logic [otsu_pkg::PIX_W-1:0] rsp_threshold
);
   import otsu_pkg::*;

   // histogram
   logic [CNT_W-1:0] hist_mem [LEVELS];
   logic [LEVELS-1:0] hv_ff;
   logic [CNT_W-1:0] rd_ff;
   logic             rdv_ff;
   logic [PIX_W-1:0] rd_addr, pix_bin;

   // binning stage and write-back forward
   logic             b_vld_ff, w_vld_ff;
   logic [PIX_W-1:0] b_addr_ff, w_addr_ff;
   logic [CNT_W-1:0] w_val_ff, b_cnt;

   // image totals
   logic [CNT_W-1:0] seen_ff;
   logic [SUM_W-1:0] tot_s_ff;
   logic [PIX_W-1:0] lo_ff, hi_ff;
   logic             keep;

   // split search
   logic [PIX_W-1:0] s_ff, best_ff, thr_ff;
   logic [CNT_W-1:0] n1_ff, n2, cnt;
   logic [SUM_W-1:0] s1_ff, sc;
   logic [A_W-1:0]   a_ff, d_ff, pa;
   logic [SQ_W-1:0]  sq_ff, bs_ff;
   logic [PP_W-1:0]  p_ff, bp_ff;
   logic [PW-1:0]    lhs_ff;

   logic [MC_W-1:0]  mcand;
   logic [MP_W-1:0]  mplier;
   logic             mul_busy, mul_done;
   logic [PW-1:0]    mul_prod;

   assign pix_bin = (int'(req_pixel) >= LEVELS) ? PIX_W'(LEVELS - 1) : req_pixel;
   assign keep    = int'(seen_ff) < MAX_PIXELS;
   assign rd_addr = cmd.rd_search ? s_ff : pix_bin;

   always_ff @(posedge clock) begin
      rd_ff  <= hist_mem[rd_addr];
      rdv_ff <= hv_ff[rd_addr];
      if (b_vld_ff) begin
         hist_mem[b_addr_ff] <= b_cnt;
      end
   end

   always_comb begin
      if (w_vld_ff && (w_addr_ff == b_addr_ff)) begin
         b_cnt = w_val_ff + CNT_W'(1);
      end else begin
         b_cnt = (rdv_ff ? rd_ff : '0) + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         hv_ff    <= '0;
         b_vld_ff <= 1'b0;
         w_vld_ff <= 1'b0;
         seen_ff  <= '0;
         tot_s_ff <= '0;
         lo_ff    <= PIX_W'(LEVELS - 1);
         hi_ff    <= '0;
      end else begin
         b_vld_ff <= cmd.bin_take && keep;
         w_vld_ff <= b_vld_ff;
         if (b_vld_ff) begin
            hv_ff[b_addr_ff] <= 1'b1;
         end
         if (cmd.bin_take && keep) begin
            seen_ff  <= seen_ff + CNT_W'(1);
            tot_s_ff <= tot_s_ff + SUM_W'(pix_bin);
            if (pix_bin < lo_ff) lo_ff <= pix_bin;
            if (pix_bin > hi_ff) hi_ff <= pix_bin;
         end
      end
   end

   always_ff @(posedge clock) begin
      b_addr_ff <= pix_bin;
      w_addr_ff <= b_addr_ff;
      w_val_ff  <= b_cnt;
   end

   // class 1 accumulation
   assign cnt = rdv_ff ? rd_ff : '0;
   assign sc  = SUM_W'(s_ff) * SUM_W'(cnt);
   assign n2  = seen_ff - n1_ff;
   assign pa  = mul_prod[A_W-1:0];

   always_comb begin
      mcand  = '0;
      mplier = '0;
      unique case (cmd.op)
         OP_A: begin
            mcand  = MC_W'(s1_ff);
            mplier = MP_W'(seen_ff);
         end
         OP_B: begin
            mcand  = MC_W'(tot_s_ff);
            mplier = MP_W'(n1_ff);
         end
         OP_SQ: begin
            mcand  = MC_W'(d_ff);
            mplier = MP_W'(d_ff);
         end
         OP_P: begin
            mcand  = MC_W'(n1_ff);
            mplier = MP_W'(n2);
         end
         OP_L: begin
            mcand  = MC_W'(sq_ff);
            mplier = MP_W'(bp_ff);
         end
         OP_R: begin
            mcand  = MC_W'(bs_ff);
            mplier = MP_W'(p_ff);
         end
         default: begin
            mcand  = '0;
            mplier = '0;
         end
      endcase
   end

   otsu_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .mul_start  (cmd.mul_start),
      .mul_mcand  (mcand),
      .mul_mplier (mplier),
      .mul_busy   (mul_busy),
      .mul_done   (mul_done),
      .mul_prod   (mul_prod)
   );

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         s_ff    <= lo_ff;
         n1_ff   <= '0;
         s1_ff   <= '0;
         bs_ff   <= '0;
         bp_ff   <= PP_W'(1);
         best_ff <= '0;
      end else begin
         if (cmd.accum) begin
            n1_ff <= n1_ff + cnt;
            s1_ff <= s1_ff + sc;
         end
         if (cmd.step) begin
            s_ff <= s_ff + PIX_W'(1);
         end
         if (cmd.mul_latch) begin
            unique case (cmd.op)
               OP_A:  a_ff   <= pa;
               OP_B:  d_ff   <= (a_ff >= pa) ? (a_ff - pa) : (pa - a_ff);
               OP_SQ: sq_ff  <= mul_prod[SQ_W-1:0];
               OP_P:  p_ff   <= mul_prod[PP_W-1:0];
               OP_L:  lhs_ff <= mul_prod;
               OP_R: begin
                  if (lhs_ff > mul_prod) begin
                     bs_ff   <= sq_ff;
                     bp_ff   <= p_ff;
                     best_ff <= s_ff;
                  end
               end
               default: ;
            endcase
         end
      end
      if (cmd.load_rsp) begin
         thr_ff <= best_ff;
      end
   end

   assign rsp_threshold   = thr_ff;
   assign stat.no_split   = hi_ff <= lo_ff;
   assign stat.last_split = ({1'b0, s_ff} + (PIX_W + 1)'(1)) == {1'b0, hi_ff};
   assign stat.mul_done   = mul_done;
   assign stat.mul_busy   = mul_busy;

endmodule

>>> hw/rtl/otsu_ctrl.sv
module otsu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output otsu_pkg::dp_cmd_type  cmd,
   input  otsu_pkg::dp_stat_type stat
);
   import otsu_pkg::*;

   typedef enum logic [7:0] {
      ST_BIN    = 8'b0000_0001,
      ST_DRAIN  = 8'b0000_0010,
      ST_READ   = 8'b0000_0100,
      ST_ACCUM  = 8'b0000_1000,
      ST_MSTART = 8'b0001_0000,
      ST_MWAIT  = 8'b0010_0000,
      ST_NEXT   = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free, take;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == ST_BIN;
   assign take      = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.op       = op_ff;
      unique case (state_ff)
         ST_BIN: begin
            cmd.bin_take = take;
            if (take && req_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            cmd.init = 1'b1;
            state_in = stat.no_split ? ST_DONE : ST_READ;
         end
         ST_READ: begin
            cmd.rd_search = 1'b1;
            state_in      = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            op_in     = OP_A;
            state_in  = ST_MSTART;
         end
         ST_MSTART: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (stat.mul_done) begin
               cmd.mul_latch = 1'b1;
               state_in      = ST_MSTART;
               unique case (op_ff)
                  OP_A:  op_in = OP_B;
                  OP_B:  op_in = OP_SQ;
                  OP_SQ: op_in = OP_P;
                  OP_P:  op_in = OP_L;
                  OP_L:  op_in = OP_R;
                  OP_R:  state_in = ST_NEXT;
                  default: state_in = ST_NEXT;
               endcase
            end
         end
         ST_NEXT: begin
            if (stat.last_split) begin
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               cmd.clear    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_BIN;
            end
         end
         default: state_in = ST_BIN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BIN;
         op_ff        <= OP_A;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> !stat.mul_busy)
      else $error("multiplier started while busy");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before taken");

   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> !req_ready)
      else $error("pixel taken after last of image");

   a_wait_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MSTART) |=> (stat.mul_busy || stat.mul_done))
      else $error("multiplier did not start");

endmodule

>>> hw/rtl/otsu_threshold_select_core.sv
// Otsu threshold select. Pixel words (req_pixel, req_last) are binned into a
// 256-bin histogram at one word per cycle; req_ready drops after the word
// marked last and stays low while the split search runs. The search visits
// each split from the lowest to one below the highest occupied bin. Per split
// it takes a histogram read, an accumulate, a step and six products on one
// shared shift-add multiplier. Each product takes a start, a shift-add pass
// over the multiplier bits that ends when no ones remain, and a latch. The
// multiplier dominates the search time. The threshold (0 when no split
// scores above zero) then sits in an output register while binning of the
// next image already proceeds. The histogram is cleared at once at the end
// of each image; words beyond MAX_PIXELS in one image are dropped, but a
// dropped last word still ends the image.
module otsu_threshold_select_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [otsu_pkg::PIX_W-1:0] req_pixel,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [otsu_pkg::PIX_W-1:0] rsp_threshold
);
   import otsu_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencing: binning, split loop, multiply steps, result handoff
   otsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // histogram memory, class sums, multiplier, best-score registers
   otsu_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_pixel     (req_pixel),
      .rsp_threshold (rsp_threshold)
   );

endmodule

>>> test/otsu_threshold_select_core_test.sv
`timescale 1ns / 1ps

module otsu_threshold_select_core_test;
   import otsu_pkg::*;

   // the search can run up to 255 splits, each with six multiplier products
   localparam int IDLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 100;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [PIX_W-1:0] req_pixel = '0;
   logic             req_last = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [PIX_W-1:0] rsp_threshold;

   // model copy of the histogram for the image in flight
   int unsigned      hist[LEVELS];
   int unsigned      pixels_binned;
   logic [PIX_W-1:0] threshold_queue[$];
   int               mismatches;
   int               idle_cycles;
   bit               slow_receiver;

   otsu_threshold_select_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pixel(req_pixel), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_threshold(rsp_threshold)
   );

   always #5 clock = ~clock;

   // Otsu split search; exact compare sq*bp > bs*p, 256-bit product sides
   function automatic logic [PIX_W-1:0] otsu_split();
      longint unsigned tot_n, tot_s, n1, s1, n2, a, b, d, p, bp;
      logic [127:0]    sq, bs;
      logic [255:0]    lhs, rhs;
      int              lo, hi;
      logic [PIX_W-1:0] split;
      tot_n = 0; tot_s = 0; lo = -1; hi = -1;
      n1 = 0; s1 = 0; bs = '0; bp = 1; split = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (hist[i] != 0) begin
            if (lo < 0) lo = i;
            hi = i;
         end
         tot_n += hist[i];
         tot_s += longint'(i) * hist[i];
      end
      if (lo < 0) return '0;
      for (int s = lo; s < hi; s++) begin
         n1 += hist[s];
         s1 += longint'(s) * hist[s];
         n2 = tot_n - n1;
         a = s1 * tot_n;
         b = tot_s * n1;
         d = (a >= b) ? a - b : b - a;
         p = n1 * n2;
         sq = 128'(d) * 128'(d);
         lhs = 256'(sq) * 256'(bp);
         rhs = 256'(bs) * 256'(p);
         if (lhs > rhs) begin
            bs = sq;
            bp = p;
            split = PIX_W'(s);
         end
      end
      return split;
   endfunction

   task automatic clear_hist();
      foreach (hist[i]) hist[i] = 0;
      pixels_binned = 0;
   endtask

   // valid drops only when a real gap follows
   task automatic sender_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) n = 0;
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // send one pixel word, update the histogram and the expected thresholds
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit last, input bit gaps = 1);
      if (gaps) sender_gap();
      req_valid <= 1'b1;
      req_pixel <= pix;
      req_last  <= last;
      do @(posedge clock); while (!req_ready);
      if (pixels_binned < MAX_PIXELS) begin
         hist[pix]++;
         pixels_binned++;
      end
      if (last) begin
         threshold_queue.push_back(otsu_split());
         clear_hist();
      end
   endtask

   task automatic send_image(input int len, input int mode);
      logic [PIX_W-1:0] base, pix;
      int spread;
      base = PIX_W'($urandom);
      spread = $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: pix = PIX_W'($urandom);
            1: pix = PIX_W'((($urandom_range(0, 1) == 0) ? base : ~base)
                            + $urandom_range(0, spread));
            default: pix = PIX_W'(base + $urandom_range(0, 3));
         endcase
         send_pixel(pix, i == len - 1);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (threshold_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      send_pixel(8'd0, 1'b1);                     // single pixel, single level
      send_pixel(8'd255, 1'b0); send_pixel(8'd255, 1'b1);
      send_pixel(8'd0, 1'b0); send_pixel(8'd255, 1'b1);   // extremes
      send_pixel(8'd10, 1'b0); send_pixel(8'd20, 1'b0);
      send_pixel(8'd30, 1'b1);                    // equal scores: tie keeps first
      send_pixel(8'd1, 1'b0); send_pixel(8'd2, 1'b0);
      send_pixel(8'd2, 1'b0); send_pixel(8'd200, 1'b1);
      send_pixel(8'hAA, 1'b0); send_pixel(8'h55, 1'b0);
      send_pixel(8'h0F, 1'b0); send_pixel(8'hF0, 1'b1);
      send_pixel(8'd7, 1'b0); send_pixel(8'd7, 1'b0); send_pixel(8'd7, 1'b1);
   endtask

   task automatic test_drain_pause();
      send_image(12, 1);
      wait_drained();          // sender holds off until all thresholds are back
      send_image(6, 0);
   endtask

   task automatic test_random();
      int sent;
      sent = 0;
      while (sent < 500) begin
         int len, mode;
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
         mode = $urandom_range(0, 2);
         slow_receiver = ($urandom_range(0, 3) == 0);
         send_image(len, mode);
         sent += len;
      end
      slow_receiver = 1'b0;
   endtask

   // receiver: random stalls, with slow stretches where ready is rare
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (!slow_receiver) rsp_ready <= ($urandom_range(0, 7) != 0);
      else rsp_ready <= ($urandom_range(0, 19) == 0);
   end

   // checker: each accepted threshold against the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (threshold_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected threshold word %0d", rsp_threshold);
         end else begin
            logic [PIX_W-1:0] exp_th;
            exp_th = threshold_queue.pop_front();
            if (rsp_threshold !== exp_th) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("threshold mismatch: expected %0d actual %0d", exp_th, rsp_threshold);
            end
         end
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      mismatches = 0;
      idle_cycles = 0;
      slow_receiver = 1'b0;
      clear_hist();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_drain_pause();
      test_random();
      wait_drained();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
